// ----- rtl/core/bfld_pkg.sv -----
package bfld_pkg;

  // Pixel formats.
  localparam logic [1:0] FMT_ONE   = 2'd0;
  localparam logic [1:0] FMT_TWO   = 2'd1;
  localparam logic [1:0] FMT_FOUR  = 2'd2;
  localparam logic [1:0] FMT_THREE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_STREAM = 2'd3;

  localparam int unsigned CFG_W   = 13;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PART_W  = 10;
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned OPOS_W  = 11;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

  typedef logic [3:0][CHAN_W-1:0] pix_t;
  typedef logic [3:0][PART_W-1:0] part_t;
  typedef logic [3:0][SUM_W-1:0]  colsum_t;

endpackage

// ----- rtl/core/bfld_ram.sv -----
module bfld_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/box_filter_lod_downsampler.sv -----
// Box-filter level-of-detail downsampler. Source pixels enter one item per
// clock in raster order while the output register can take a result; with
// the reduced image enabled, each square block of 2x2 or 4x4 pixels yields
// one averaged item, registered in the cycle after the block's bottom-right
// pixel is accepted. The column-sum memory is read at the first pixel of each
// block row and written at its last pixel, so the read-modify-write never
// overlaps itself. It holds MAX_WIDTH/2 entries of four 12-bit channel
// sums, needs no clearing pass, and its read data is only used on rows
// written earlier in the same image.
// Registers should be written between images; the position counters are not
// cleared by a write.
module box_filter_lod_downsampler #(
  parameter int unsigned MAX_WIDTH    = 4096,
  parameter int unsigned MIN_LOD_SIZE = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration port.
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bfld_pkg::CFG_W-1:0]    cfg_wdata,
  // Source pixel channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bfld_pkg::CHAN_W-1:0]   in_chan_red,
  input  logic [bfld_pkg::CHAN_W-1:0]   in_chan_green,
  input  logic [bfld_pkg::CHAN_W-1:0]   in_chan_blue,
  input  logic [bfld_pkg::CHAN_W-1:0]   in_chan_alpha,
  // Reduced pixel channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfld_pkg::CHAN_W-1:0]   out_avg_red,
  output logic [bfld_pkg::CHAN_W-1:0]   out_avg_green,
  output logic [bfld_pkg::CHAN_W-1:0]   out_avg_blue,
  output logic [bfld_pkg::CHAN_W-1:0]   out_avg_alpha,
  output logic [bfld_pkg::OPOS_W-1:0]   out_col,
  output logic [bfld_pkg::OPOS_W-1:0]   out_row,
  output logic                          out_last_of_image
);

  import bfld_pkg::*;

  localparam int unsigned SUM_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned ADDR_W    = $clog2(SUM_DEPTH);
  localparam int unsigned MEM_W     = 4 * SUM_W;

  // Configuration registers.
  logic [1:0]       fmt_r;
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic             stream_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_FOUR;
      width_r  <= 13'd256;
      height_r <= 13'd256;
      stream_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORMAT: fmt_r    <= cfg_wdata[1:0];
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        REG_STREAM: stream_r <= cfg_wdata[0];
        default:    fmt_r    <= fmt_r;
      endcase
    end
  end

  // Block geometry, derived from the live registers so a write applies to
  // the very next item.
  logic             f4;
  logic             lod_en;
  logic [POS_W-1:0] red_w, red_h;

  always_comb begin
    f4 = (width_r[12:1] > 12'd2) && (height_r[12:1] > 12'd2);
    lod_en = (width_r >= MIN_LOD_SIZE) && (height_r >= MIN_LOD_SIZE) &&
             !width_r[0] && !height_r[0] && (width_r <= MAX_WIDTH) &&
             (f4 ? (width_r > 13'd4 && height_r > 13'd4)
                 : (width_r > 13'd2 && height_r > 13'd2)) &&
             !stream_r;
    red_w = f4 ? {2'b00, width_r[12:2]}  : {1'b0, width_r[12:1]};
    red_h = f4 ? {2'b00, height_r[12:2]} : {1'b0, height_r[12:1]};
  end

  // Source position counters.
  logic [POS_W-1:0] col_r, row_r;
  logic [POS_W-1:0] col_nxt, row_nxt;
  logic [POS_W:0]   col_inc, row_inc;
  logic             in_fire;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    col_inc = {1'b0, col_r} + 14'd1;
    row_inc = {1'b0, row_r} + 14'd1;
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (col_inc >= {1'b0, width_r}) begin
        col_nxt = '0;
        row_nxt = (row_inc >= {1'b0, height_r}) ? '0 : row_inc[POS_W-1:0];
      end else begin
        col_nxt = col_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Position within the block and the reduced-image coordinates.
  logic [POS_W-1:0] bx, by;
  logic             first_col, last_col, first_row, last_row;
  logic             act;

  always_comb begin
    bx        = f4 ? {2'b00, col_r[12:2]} : {1'b0, col_r[12:1]};
    by        = f4 ? {2'b00, row_r[12:2]} : {1'b0, row_r[12:1]};
    first_col = f4 ? (col_r[1:0] == 2'd0) : !col_r[0];
    last_col  = f4 ? (col_r[1:0] == 2'd3) : col_r[0];
    first_row = f4 ? (row_r[1:0] == 2'd0) : !row_r[0];
    last_row  = f4 ? (row_r[1:0] == 2'd3) : row_r[0];
    act       = in_fire && lod_en && (bx < red_w) && (by < red_h) && (bx < SUM_DEPTH);
  end

  // Channel selection by format.
  pix_t px;

  always_comb begin
    px[0] = in_chan_red;
    px[1] = (fmt_r != FMT_ONE) ? in_chan_green : '0;
    px[2] = (fmt_r == FMT_FOUR || fmt_r == FMT_THREE) ? in_chan_blue : '0;
    unique case (fmt_r)
      FMT_FOUR:  px[3] = in_chan_alpha;
      FMT_THREE: px[3] = ALPHA_OPAQUE;
      default:   px[3] = '0;
    endcase
  end

  // Running sum across the current block row.
  part_t part_r, part_new;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      part_new[c] = first_col ? {2'b00, px[c]} : part_r[c] + {2'b00, px[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
    end else if (act) begin
      part_r <= part_new;
    end
  end

  // Column-sum memory. The entry for this block column is fetched at the
  // first pixel of a block row; the row's last pixel comes later and writes
  // back. The next read of the same entry comes a whole source row later,
  // so no forwarding path is needed.
  logic              rd_en, wr_en, ld_out;
  logic [ADDR_W-1:0] addr;
  colsum_t           rd_sum, new_sum;

  assign rd_en  = act && first_col;
  assign wr_en  = act && last_col;
  assign ld_out = wr_en && last_row;
  assign addr   = ADDR_W'(bx);

  bfld_ram #(
    .WIDTH(MEM_W),
    .DEPTH(SUM_DEPTH)
  ) u_colsum (
    .clk  (clk),
    .we   (wr_en),
    .waddr(addr),
    .wdata(new_sum),
    .re   (rd_en),
    .raddr(addr),
    .rdata(rd_sum)
  );

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      new_sum[c] = first_row ? {2'b00, part_new[c]} : rd_sum[c] + {2'b00, part_new[c]};
    end
  end

  // Output register. It parts the two channels, so a new item is taken
  // whenever the held result is leaving or there is none.
  logic              out_valid_r;
  pix_t              avg_r;
  logic [OPOS_W-1:0] ocol_r, orow_r;
  logic              olast_r;

  assign in_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      for (int c = 0; c < 4; c++) begin
        avg_r[c] <= f4 ? new_sum[c][11:4] : new_sum[c][9:2];
      end
      ocol_r  <= bx[OPOS_W-1:0];
      orow_r  <= by[OPOS_W-1:0];
      olast_r <= (bx == red_w - 13'd1) && (by == red_h - 13'd1);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_avg_red       = avg_r[0];
  assign out_avg_green     = avg_r[1];
  assign out_avg_blue      = avg_r[2];
  assign out_avg_alpha     = avg_r[3];
  assign out_col           = ocol_r;
  assign out_row           = orow_r;
  assign out_last_of_image = olast_r;

  // A result is only produced by a write-back of the column sum.
  a_out_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out |-> (wr_en && in_fire))
    else $error("result loaded without a column-sum write");

  // A single block never reads and writes the memory in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("column-sum read and write in the same cycle");

  // With the reduced image off, no result may appear.
  a_off_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !lod_en) |=> !out_valid_r)
    else $error("result produced while the reduced image is disabled");

endmodule
